>>> rtl/core/wsfd_pkg.sv
// wsfd_pkg: shared types and constants for the websocket frame deframer
// no dependencies; used by the interfaces, the deframer and its checker
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_B0  = 3'd0,
    PH_B1  = 3'd1,
    PH_EXT = 3'd2,
    PH_KEY = 3'd3,
    PH_PAY = 3'd4
  } phase_e;

  localparam logic       KIND_HEADER  = 1'b0;
  localparam logic       KIND_PAYLOAD = 1'b1;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // header bytes still expected in a phase, minus one
  localparam logic [2:0] EXT16_LEFT = 3'd1;
  localparam logic [2:0] EXT64_LEFT = 3'd7;
  localparam logic [2:0] KEY_LEFT   = 3'd3;

  localparam int unsigned LEN_W = 64;

  typedef struct packed {
    logic             item_kind;
    logic [7:0]       out_byte;
    logic             fin_flag;
    logic [3:0]       frame_opcode;
    logic             masked_flag;
    logic [LEN_W-1:0] payload_length;
    logic             last_of_frame;
  } result_t;

endpackage

>>> rtl/core/wsfd_if.sv
// wsfd_if: valid/ready channels of the websocket frame deframer
// depends on wsfd_pkg for the length width
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsfd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      item_kind;
  logic [7:0]                out_byte;
  logic                      fin_flag;
  logic [3:0]                frame_opcode;
  logic                      masked_flag;
  logic [wsfd_pkg::LEN_W-1:0] payload_length;
  logic                      last_of_frame;

  modport source (output valid, output item_kind, output out_byte, output fin_flag,
                  output frame_opcode, output masked_flag, output payload_length,
                  output last_of_frame, input ready);
  modport sink   (input valid, input item_kind, input out_byte, input fin_flag,
                  input frame_opcode, input masked_flag, input payload_length,
                  input last_of_frame, output ready);
endinterface

>>> rtl/core/websocket_frame_deframer.sv
// websocket_frame_deframer: parses a byte stream of websocket frames, one byte per transfer
// each result is registered: it appears in the output register in the cycle after the byte that causes it
// throughput: one byte per cycle; while a result waits, a byte is taken only as it drains
// header bytes give no result; the last header byte gives the header result
// reset (rst_ni low, async) returns to the first header byte with all holds cleared
// depends on wsfd_pkg and wsfd_if
module websocket_frame_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,
  wsfd_in_if.sink      in_i,
  wsfd_out_if.source   out_o
);

  wsfd_pkg::phase_e              phase_q, phase_d;
  logic                          fin_q, fin_d;
  logic [3:0]                    opcode_q, opcode_d;
  logic                          mask_q, mask_d;
  logic [wsfd_pkg::LEN_W-1:0]    length_q, length_d;
  logic [2:0]                    count_q, count_d;
  logic [31:0]                   key_q, key_d;
  logic [wsfd_pkg::LEN_W-1:0]    remaining_q, remaining_d;
  logic [1:0]                    key_index_q, key_index_d;

  logic                          out_valid_q;
  wsfd_pkg::result_t             res_q, res_d;

  logic                          accept;
  logic                          emit;
  logic                          hdr_done;
  logic [7:0]                    b;
  logic [7:0]                    key_byte;
  logic [wsfd_pkg::LEN_W-1:0]    rem_dec;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  // first key byte sits in bits 31..24
  assign key_byte   = key_q[{~key_index_q, 3'b000} +: 8];
  assign rem_dec    = remaining_q - {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1};

  always_comb begin
    phase_d     = phase_q;
    fin_d       = fin_q;
    opcode_d    = opcode_q;
    mask_d      = mask_q;
    length_d    = length_q;
    count_d     = count_q;
    key_d       = key_q;
    remaining_d = remaining_q;
    key_index_d = key_index_q;
    emit        = 1'b0;
    hdr_done    = 1'b0;
    res_d       = res_q;

    if (accept) begin
      case (phase_q)
        wsfd_pkg::PH_B1: begin
          mask_d = b[7];
          if (b[6:0] == wsfd_pkg::LEN_CODE_16) begin
            length_d = '0;
            phase_d  = wsfd_pkg::PH_EXT;
            count_d  = wsfd_pkg::EXT16_LEFT;
          end else if (b[6:0] == wsfd_pkg::LEN_CODE_64) begin
            length_d = '0;
            phase_d  = wsfd_pkg::PH_EXT;
            count_d  = wsfd_pkg::EXT64_LEFT;
          end else begin
            length_d = {{(wsfd_pkg::LEN_W-7){1'b0}}, b[6:0]};
            if (mask_d) begin
              phase_d = wsfd_pkg::PH_KEY;
              count_d = wsfd_pkg::KEY_LEFT;
              key_d   = '0;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        wsfd_pkg::PH_EXT: begin
          length_d = {length_q[wsfd_pkg::LEN_W-9:0], b};
          if (count_q != 3'd0) begin
            count_d = count_q - 3'd1;
          end else if (mask_q) begin
            phase_d = wsfd_pkg::PH_KEY;
            count_d = wsfd_pkg::KEY_LEFT;
            key_d   = '0;
          end else begin
            hdr_done = 1'b1;
          end
        end
        wsfd_pkg::PH_KEY: begin
          key_d = {key_q[23:0], b};
          if (count_q != 3'd0) begin
            count_d = count_q - 3'd1;
          end else begin
            hdr_done = 1'b1;
          end
        end
        wsfd_pkg::PH_PAY: begin
          emit                 = 1'b1;
          res_d.item_kind      = wsfd_pkg::KIND_PAYLOAD;
          res_d.out_byte       = mask_q ? (b ^ key_byte) : b;
          res_d.fin_flag       = fin_q;
          res_d.frame_opcode   = opcode_q;
          res_d.masked_flag    = mask_q;
          res_d.payload_length = length_q;
          res_d.last_of_frame  = (rem_dec == '0);
          key_index_d          = key_index_q + 2'd1;
          remaining_d          = rem_dec;
          if (rem_dec == '0) begin
            phase_d = wsfd_pkg::PH_B0;
          end
        end
        default: begin
          // unused phase codes act as the first header byte
          fin_d    = b[7];
          opcode_d = b[3:0];
          phase_d  = wsfd_pkg::PH_B1;
        end
      endcase

      if (hdr_done) begin
        emit                 = 1'b1;
        res_d.item_kind      = wsfd_pkg::KIND_HEADER;
        res_d.out_byte       = '0;
        res_d.fin_flag       = fin_q;
        res_d.frame_opcode   = opcode_q;
        res_d.masked_flag    = mask_d;
        res_d.payload_length = length_d;
        res_d.last_of_frame  = (length_d == '0);
        remaining_d          = length_d;
        key_index_d          = 2'd0;
        phase_d              = (length_d == '0) ? wsfd_pkg::PH_B0 : wsfd_pkg::PH_PAY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wsfd_pkg::PH_B0;
      fin_q       <= 1'b0;
      opcode_q    <= '0;
      mask_q      <= 1'b0;
      length_q    <= '0;
      count_q     <= '0;
      key_q       <= '0;
      remaining_q <= '0;
      key_index_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      fin_q       <= fin_d;
      opcode_q    <= opcode_d;
      mask_q      <= mask_d;
      length_q    <= length_d;
      count_q     <= count_d;
      key_q       <= key_d;
      remaining_q <= remaining_d;
      key_index_q <= key_index_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register loads on every result, header or payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.item_kind      = res_q.item_kind;
  assign out_o.out_byte       = res_q.out_byte;
  assign out_o.fin_flag       = res_q.fin_flag;
  assign out_o.frame_opcode   = res_q.frame_opcode;
  assign out_o.masked_flag    = res_q.masked_flag;
  assign out_o.payload_length = res_q.payload_length;
  assign out_o.last_of_frame  = res_q.last_of_frame;

endmodule

>>> rtl/core/wsfd_checker.sv
// wsfd_checker: port-level assertions for websocket_frame_deframer, bound into every instance of it
// depends on wsfd_pkg
module wsfd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         item_kind_i,
  input logic [7:0]                   out_byte_i,
  input logic [wsfd_pkg::LEN_W-1:0]   payload_length_i,
  input logic                         last_of_frame_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // no byte is taken while a waiting result is not drained
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken over a stalled result");

  // header result is last exactly for an empty frame
  a_hdr_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && item_kind_i == wsfd_pkg::KIND_HEADER
      |-> last_of_frame_i == (payload_length_i == '0))
    else $error("header last flag does not match payload length");

  // header results carry a zero data byte
  a_hdr_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && item_kind_i == wsfd_pkg::KIND_HEADER |-> out_byte_i == 8'd0)
    else $error("header result with nonzero data byte");

  // a newly offered result follows a byte transfer in the cycle before
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without a byte transfer");

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .item_kind_i      (out_o.item_kind),
  .out_byte_i       (out_o.out_byte),
  .payload_length_i (out_o.payload_length),
  .last_of_frame_i  (out_o.last_of_frame)
);
